// ===== sv/ist_pkg.sv =====
package ist_pkg;

    // default table depth
    localparam int CAPACITY_DEFAULT = 128;

    // request kinds carried on tuser
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 8;

    // result item: ok, was_present, count_after, zero pad
    localparam int OUT_USED_W = 2 + COUNT_OUT_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

endpackage

// ===== sv/ist_ram.sv =====
module ist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/integer_set_table.sv =====
// Set of up to CAPACITY distinct 32-bit integers held unordered in one RAM with an
// occupancy count. Each request item (tuser = kind: lookup, insert, remove; tdata =
// value) gets one result item. The table is searched linearly, one RAM read per cycle,
// stopping at the first match or after the last occupied entry (a request on an empty
// table skips the search); a removal that hits then fetches the last entry and moves it
// into the freed slot. Only one request is in flight at a time; the result waits in an
// output register, so the next request can start while the previous result has not
// been taken, and that next result holds in its last step until the register is free.
// The RAM needs no clearing after reset: only entries below the count are ever read.
module integer_set_table #(
    parameter int CAPACITY = ist_pkg::CAPACITY_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ist_pkg::VALUE_W-1:0]    s_axis_tdata,   // value
    input  logic [ist_pkg::MODE_W-1:0]     s_axis_tuser,   // mode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ist_pkg::OUT_DATA_W-1:0] m_axis_tdata    // ok, was_present, count_after
);
    import ist_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_MOVE,
        ST_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic                    chk_vld_reg, chk_vld_next;
    logic [AW-1:0]           chk_idx_reg, chk_idx_next;
    logic                    present_reg, present_next;
    logic [AW-1:0]           slot_reg, slot_next;
    logic                    ok_reg, ok_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    logic [VALUE_W-1:0]      ram_wr_data;
    logic                    ram_rd_en;
    logic [AW-1:0]           ram_rd_addr;
    logic [VALUE_W-1:0]      ram_rd_data;

    logic                    hit;
    logic [CW-1:0]           count_dec;

    ist_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_entries (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign hit       = chk_vld_reg && (ram_rd_data == $unsigned(value_reg));
    assign count_dec = count_reg - CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        present_next   = present_reg;
        slot_next      = slot_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = count_reg[AW-1:0];
        ram_wr_data = $unsigned(value_reg);
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg[AW-1:0];

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next    = s_axis_tuser;
                    value_next   = $signed(s_axis_tdata);
                    idx_next     = '0;
                    chk_vld_next = 1'b0;
                    present_next = 1'b0;
                    state_next   = (count_reg == '0) ? ST_RESOLVE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // check the entry read last cycle while issuing the next read
                if (hit)
                begin
                    present_next = 1'b1;
                    slot_next    = chk_idx_reg;
                    chk_vld_next = 1'b0;
                    state_next   = ST_RESOLVE;
                end
                else if (idx_reg != count_reg)
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = idx_reg[AW-1:0];
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg[AW-1:0];
                    idx_next     = idx_reg + CW'(1);
                end
                else
                begin
                    chk_vld_next = 1'b0;
                    state_next   = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                state_next = ST_RESP;
                unique case (mode_reg)
                    MODE_LOOKUP:
                    begin
                        ok_next = present_reg;
                    end
                    MODE_INSERT:
                    begin
                        if (present_reg)
                        begin
                            ok_next = 1'b1;
                        end
                        else if (count_reg != CAP_C)
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = count_reg[AW-1:0];
                            count_next  = count_reg + CW'(1);
                            ok_next     = 1'b1;
                        end
                        else
                        begin
                            ok_next = 1'b0;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (present_reg)
                        begin
                            // fetch the last entry to fill the hole
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = count_dec[AW-1:0];
                            ok_next     = 1'b1;
                            state_next  = ST_MOVE;
                        end
                        else
                        begin
                            ok_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ST_MOVE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = slot_reg;
                ram_wr_data = ram_rd_data;
                count_next  = count_dec;
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{OUT_PAD_W{1'b0}}, COUNT_OUT_W'(count_reg),
                                      present_reg, ok_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        value_reg    <= value_next;
        idx_reg      <= idx_next;
        chk_idx_reg  <= chk_idx_next;
        present_reg  <= present_next;
        slot_reg     <= slot_next;
        ok_reg       <= ok_next;
        out_data_reg <= out_data_next;
    end

    // occupancy stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("occupancy above capacity");

    // the search never writes the table
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !ram_wr_en)
        else $error("table write during search");

    // the count does not move during a search
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |=> $stable(count_reg))
        else $error("count changed during search");

    // a result is loaded only when the output register is free or draining
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && out_valid_reg && !m_axis_tready) |=> state_reg == ST_RESP)
        else $error("result dropped while output stalled");

    // an accepted item starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> state_reg != ST_IDLE)
        else $error("accepted item not started");

endmodule
